FILE: sv/abt_pkg.sv
// Shared types and constants for the arena bump allocator table.
package abt_pkg;

    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 32;
    localparam int OWNER_W = 22;
    localparam int INDEX_W = 7;

    typedef enum logic [3:0] {
        REQ_CREATE    = 4'd0,
        REQ_ALLOC     = 4'd1,
        REQ_SEEK      = 4'd2,
        REQ_POP       = 4'd3,
        REQ_POS       = 4'd4,
        REQ_RESERVE   = 4'd5,
        REQ_DESTROY   = 4'd6,
        REQ_SIZE      = 4'd7,
        REQ_BOOTSTRAP = 4'd8,
        REQ_BASE      = 4'd9,
        REQ_MAP       = 4'd10,
        REQ_RELEASE   = 4'd11
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_SIZE  = 3'd4,
        ST_BAD_INDEX = 3'd5,
        ST_UNKNOWN   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_RELEASE,
        S_BPARENT
    } t_state;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_W-1:0]    base;
        logic [SIZE_W-1:0]    cursor;
        logic [SIZE_W-1:0]    size;
        logic                 is_sub;
        logic [OWNER_W-1:0]   owner;
    } t_entry;

    typedef struct packed {
        t_status status;
        logic    wr_en;
        logic    need_scan;
    } t_exec_ctl;

endpackage

FILE: sv/arena_bump_allocator_table_core.sv
// Top level of the arena bump allocator table: request sequencer around the arena memory.
// Usage: a transaction is accepted at a rising edge with start high and busy low. Each
// transaction yields exactly one result, shown for one cycle with o_valid high on
// o_status, o_result_index, o_result_address and o_result_size; the receiver cannot
// stall it. All arena state lives in one table memory with one read and one write port
// and a registered read.
// Unknown requests and indices beyond the table show their result in the cycle after
// accept. Alloc, seek, pop, pos, reserve, destroy, size, base and map, and requests to
// an invalid slot, read the entry in S_READ and show the result after it. A create walks
// the table one entry per cycle in S_SCAN to find the first free slot. A bootstrap reads
// the parent, walks the table for a free slot and writes the parent back in S_BPARENT. A
// release walks the whole table. The next transaction can be accepted in the cycle its
// predecessor's result is shown. After reset, busy stays high while every table entry is
// written to zero. PAGE_BYTES must be a power of two; create sizes are rounded up to it.
module arena_bump_allocator_table_core
    import abt_pkg::*;
#(
    parameter int SLOT_COUNT = 128,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [3:0]          i_req_type,
    input  logic [INDEX_W-1:0]  i_slot_index,
    input  logic [SIZE_W-1:0]   i_amount,
    input  logic [OWNER_W-1:0]  i_owner_id,
    input  logic [ADDR_W-1:0]   i_map_address,
    output logic                o_valid,
    output logic [2:0]          o_status,
    output logic [INDEX_W-1:0]  o_result_index,
    output logic [ADDR_W-1:0]   o_result_address,
    output logic [SIZE_W-1:0]   o_result_size
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SIZE_W:0] PAGE_MASK = (SIZE_W + 1)'(PAGE_BYTES - 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [SIZE_W-1:0]  r_acc, n_acc;
    logic               r_valid;
    t_status            r_status;
    logic [INDEX_W-1:0] r_index;
    logic [ADDR_W-1:0]  r_addr;
    logic [SIZE_W-1:0]  r_size;

    t_req               r_req;
    logic [AW-1:0]      r_idx;
    logic [SIZE_W-1:0]  r_amt;
    logic [OWNER_W-1:0] r_owner;
    logic [ADDR_W-1:0]  r_maddr;
    t_entry             r_parent;
    t_entry             r_child;
    logic [INDEX_W-1:0] r_slot;

    logic               accept;
    logic               req_unknown;
    logic               req_indexed;
    logic               idx_ok;
    logic [10:0]        idx_wide;
    logic [10:0]        cnt_wide;
    logic               cnt_last;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    t_entry             rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_data;

    logic               res_ld;
    t_status            res_status;
    logic [INDEX_W-1:0] res_index;
    logic [ADDR_W-1:0]  res_addr;
    logic [SIZE_W-1:0]  res_size;

    t_exec_ctl          ex_ctl;
    logic [ADDR_W-1:0]  ex_address;
    logic [SIZE_W-1:0]  ex_size;
    t_entry             ex_entry;
    t_entry             ex_child;

    logic [SIZE_W:0]    round_sum;
    logic [SIZE_W:0]    rounded;
    logic               bad_size;
    logic [SIZE_W:0]    acc_sum;
    logic               owner_hit;
    t_entry             new_entry;

    assign accept      = start && !busy;
    assign req_unknown = i_req_type > REQ_RELEASE;
    assign req_indexed = !req_unknown && i_req_type != REQ_CREATE && i_req_type != REQ_RELEASE;
    assign idx_ok      = 32'(i_slot_index) < 32'(SLOT_COUNT);
    assign idx_wide    = 11'(i_slot_index);
    assign cnt_wide    = 11'(r_cnt);
    assign cnt_last    = r_cnt == AW'(SLOT_COUNT - 1);

    assign round_sum = {1'b0, r_amt} + PAGE_MASK;
    assign rounded   = round_sum & ~PAGE_MASK;
    assign bad_size  = rounded == '0 || rounded[SIZE_W];
    assign owner_hit = rd_data.valid && rd_data.owner == r_owner;
    assign acc_sum   = {1'b0, r_acc} + {1'b0, (rd_data.is_sub ? SIZE_W'(0) : rd_data.size)};

    always_comb begin
        new_entry       = '0;
        new_entry.valid = 1'b1;
        new_entry.size  = rounded[SIZE_W-1:0];
        new_entry.owner = r_owner;
    end

    abt_table #(
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    abt_exec u_exec (
        .i_req         (r_req),
        .i_amount      (r_amt),
        .i_map_address (r_maddr),
        .i_entry       (rd_data),
        .o_ctl         (ex_ctl),
        .o_address     (ex_address),
        .o_size        (ex_size),
        .o_entry       (ex_entry),
        .o_child       (ex_child)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_CREATE) begin
                        n_state = S_SCAN;
                    end else if (i_req_type == REQ_RELEASE) begin
                        n_state = S_RELEASE;
                    end else if (req_indexed && idx_ok) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = (rd_data.valid && ex_ctl.need_scan) ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (!rd_data.valid) begin
                    n_state = (r_req == REQ_BOOTSTRAP) ? S_BPARENT : S_IDLE;
                end else if (cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RELEASE: begin
                if (cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_BPARENT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = r_cnt;
        wr_data    = '0;
        res_ld     = 1'b0;
        res_status = ST_OK;
        res_index  = '0;
        res_addr   = '0;
        res_size   = '0;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
            end
            S_IDLE: begin
                n_cnt = '0;
                n_acc = '0;
                if (accept) begin
                    if (req_unknown) begin
                        res_ld     = 1'b1;
                        res_status = ST_UNKNOWN;
                    end else if (req_indexed && !idx_ok) begin
                        res_ld     = 1'b1;
                        res_status = ST_BAD_INDEX;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = req_indexed ? idx_wide[AW-1:0] : '0;
                    end
                end
            end
            S_READ: begin
                n_cnt = '0;
                if (!rd_data.valid) begin
                    res_ld     = 1'b1;
                    res_status = ST_BAD_INDEX;
                end else if (ex_ctl.need_scan) begin
                    rd_en = 1'b1;
                end else begin
                    wr_en      = ex_ctl.wr_en;
                    wr_addr    = r_idx;
                    wr_data    = ex_entry;
                    res_ld     = 1'b1;
                    res_status = ex_ctl.status;
                    res_addr   = ex_address;
                    res_size   = ex_size;
                end
            end
            S_SCAN: begin
                rd_en   = !cnt_last;
                rd_addr = r_cnt + 1'b1;
                n_cnt   = r_cnt + 1'b1;
                if (!rd_data.valid) begin
                    rd_en = 1'b0;
                    if (r_req == REQ_BOOTSTRAP) begin
                        wr_en   = 1'b1;
                        wr_data = r_child;
                    end else if (bad_size) begin
                        res_ld     = 1'b1;
                        res_status = ST_BAD_SIZE;
                    end else begin
                        wr_en      = 1'b1;
                        wr_data    = new_entry;
                        res_ld     = 1'b1;
                        res_index  = cnt_wide[INDEX_W-1:0];
                        res_size   = rounded[SIZE_W-1:0];
                    end
                end else if (cnt_last) begin
                    res_ld     = 1'b1;
                    res_status = ST_FULL;
                end
            end
            S_RELEASE: begin
                rd_en   = !cnt_last;
                rd_addr = r_cnt + 1'b1;
                n_cnt   = r_cnt + 1'b1;
                if (owner_hit) begin
                    wr_en = 1'b1;
                    n_acc = acc_sum[SIZE_W] ? '1 : acc_sum[SIZE_W-1:0];
                end
                if (cnt_last) begin
                    res_ld   = 1'b1;
                    res_size = n_acc;
                end
            end
            S_BPARENT: begin
                wr_en     = 1'b1;
                wr_addr   = r_idx;
                wr_data   = r_parent;
                res_ld    = 1'b1;
                res_index = r_slot;
                res_addr  = r_child.base;
                res_size  = r_child.size;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= res_ld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (res_ld) begin
            r_status <= res_status;
            r_index  <= res_index;
            r_addr   <= res_addr;
            r_size   <= res_size;
        end
        if (accept) begin
            r_req   <= t_req'(i_req_type);
            r_idx   <= idx_wide[AW-1:0];
            r_amt   <= i_amount;
            r_owner <= i_owner_id;
            r_maddr <= i_map_address;
        end
        if (r_state == S_READ) begin
            r_parent <= ex_entry;
            r_child  <= ex_child;
        end
        if (r_state == S_SCAN) begin
            r_slot <= cnt_wide[INDEX_W-1:0];
        end
    end

    assign busy             = r_state != S_IDLE;
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_result_index   = r_index;
    assign o_result_address = r_addr;
    assign o_result_size    = r_size;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !wr_en)
        else $error("table written while idle");

    a_error_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |->
            o_result_index == '0 && o_result_address == '0 && o_result_size == '0)
        else $error("error result carries nonzero fields");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy || start))
        else $error("result without a transaction in flight");

endmodule

FILE: sv/abt_table.sv
// Arena table storage: one synchronous read port and one write port.
module abt_table
    import abt_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/abt_exec.sv
// Read-modify-write logic for requests that address one arena entry.
module abt_exec
    import abt_pkg::*;
(
    input  t_req               i_req,
    input  logic [SIZE_W-1:0]  i_amount,
    input  logic [ADDR_W-1:0]  i_map_address,
    input  t_entry             i_entry,
    output t_exec_ctl          o_ctl,
    output logic [ADDR_W-1:0]  o_address,
    output logic [SIZE_W-1:0]  o_size,
    output t_entry             o_entry,
    output t_entry             o_child
);

    logic [SIZE_W:0]   sum_ca;
    logic [SIZE_W-1:0] addend;
    logic [ADDR_W-1:0] addr_sum;
    logic [SIZE_W-1:0] remain;

    assign sum_ca   = {1'b0, i_entry.cursor} + {1'b0, i_amount};
    assign addend   = (i_req == REQ_SEEK) ? i_amount : i_entry.cursor;
    assign addr_sum = i_entry.base + ADDR_W'(addend);
    assign remain   = (i_entry.cursor >= i_entry.size) ? '0 : i_entry.size - i_entry.cursor;

    always_comb begin
        o_child        = '0;
        o_child.valid  = 1'b1;
        o_child.base   = addr_sum;
        o_child.size   = i_amount;
        o_child.is_sub = 1'b1;
        o_child.owner  = i_entry.owner;
    end

    always_comb begin
        o_ctl.status    = ST_OK;
        o_ctl.wr_en     = 1'b0;
        o_ctl.need_scan = 1'b0;
        o_address       = '0;
        o_size          = '0;
        o_entry         = i_entry;
        unique case (i_req)
            REQ_ALLOC: begin
                if (sum_ca <= {1'b0, i_entry.size}) begin
                    o_address      = addr_sum;
                    o_entry.cursor = sum_ca[SIZE_W-1:0];
                    o_ctl.wr_en    = 1'b1;
                end else begin
                    o_ctl.status = ST_NO_SPACE;
                end
            end
            REQ_SEEK: begin
                o_address      = addr_sum;
                o_entry.cursor = i_amount;
                o_ctl.wr_en    = 1'b1;
            end
            REQ_POP: begin
                if (i_entry.cursor < i_amount) begin
                    o_ctl.status = ST_UNDERFLOW;
                end else begin
                    o_entry.cursor = i_entry.cursor - i_amount;
                    o_ctl.wr_en    = 1'b1;
                end
            end
            REQ_POS: begin
                o_size = i_entry.cursor;
            end
            REQ_RESERVE: begin
                if ({1'b0, i_entry.size} < sum_ca) begin
                    o_size = remain;
                end else begin
                    o_entry.cursor = sum_ca[SIZE_W-1:0];
                    o_size         = i_amount;
                    o_ctl.wr_en    = 1'b1;
                end
            end
            REQ_DESTROY: begin
                o_size      = i_entry.is_sub ? '0 : i_entry.size;
                o_entry     = '0;
                o_ctl.wr_en = 1'b1;
            end
            REQ_SIZE: begin
                o_size = i_entry.size;
            end
            REQ_BOOTSTRAP: begin
                if (remain < i_amount) begin
                    o_ctl.status = ST_NO_SPACE;
                end else begin
                    o_entry.cursor  = sum_ca[SIZE_W-1:0];
                    o_ctl.need_scan = 1'b1;
                end
            end
            REQ_BASE: begin
                o_address = i_entry.base;
            end
            REQ_MAP: begin
                if (i_entry.base != '0 || i_amount > i_entry.size) begin
                    o_ctl.status = ST_BAD_INDEX;
                end else begin
                    o_entry.base = i_map_address;
                    o_address    = i_map_address;
                    o_size       = i_entry.size;
                    o_ctl.wr_en  = 1'b1;
                end
            end
            default: begin
                o_ctl.status = ST_UNKNOWN;
            end
        endcase
    end

endmodule
